[rtl/line_substring_occurrence_counter_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the line substring occurrence counter
// Shared property templates used by the top-level checks.
// ---------------------------------------------------------------------------
`ifndef LINE_SUBSTRING_OCCURRENCE_COUNTER_DEFINES_SVH
`define LINE_SUBSTRING_OCCURRENCE_COUNTER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LSOC_ASSERT_IMP(lbl, clock, resetn, ante, cons, msg) \
    lbl: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define LSOC_ASSERT_NXT(lbl, clock, resetn, ante, cons, msg) \
    lbl: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/lsoc_pkg.sv]
// ---------------------------------------------------------------------------
// lsoc_pkg
// Types and constants shared by the substring counter modules.
// ---------------------------------------------------------------------------
package lsoc_pkg;

    localparam int MAX_PATTERN_DEF = 32;
    localparam int PAT_BYTES       = 32;
    localparam int LEN_W           = 6;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;
    localparam int TOK_DEPTH       = 2;
    localparam int RES_DEPTH       = 2;

    localparam logic [7:0] NEWLINE = 8'd10;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES_3 = 3'd4;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } in_t;

    typedef struct packed {
        logic [31:0] line_number;
        logic [15:0] occurrences;
        logic        done_res;
        logic        found_none;
    } out_t;

    typedef struct packed {
        logic [LEN_W-1:0]       pattern_length;
        logic [PAT_BYTES*8-1:0] pattern;
    } cfg_t;

    // Classified request passed from the front end to the back end
    typedef struct packed {
        logic matched;
        logic newline;
        logic closing;
        logic has_bytes;
    } tok_t;

endpackage

[rtl/line_substring_occurrence_counter.sv]
// Throughput: one text byte per clock, sustained, as long as results are popped.
// Path: a result becomes visible (empty low) once its byte has been written
//   into the request queue and then, through the counter stage, into the result queue.
// Reset (rst_n low, asynchronous): pattern registers, counters and both
//   queues clear at once; no clearing pass, the block takes bytes right after.
// ---------------------------------------------------------------------------
// line_substring_occurrence_counter
// Counts leftmost non-overlapping pattern matches per newline-ended line.
// ---------------------------------------------------------------------------
`include "line_substring_occurrence_counter_defines.svh"

module line_substring_occurrence_counter #(
    parameter int MAX_PATTERN = lsoc_pkg::MAX_PATTERN_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Text side
    input  logic                                 push,
    output logic                                 full,
    input  lsoc_pkg::in_t                        item,
    // Result side
    output logic                                 empty,
    input  logic                                 pop,
    output lsoc_pkg::out_t                       result,
    // Configuration writes
    input  logic                                 cfg_we,
    input  logic [lsoc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lsoc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import lsoc_pkg::*;

    // Pattern registers
    logic [LEN_W-1:0] pattern_length_reg;
    logic [63:0]      pattern_bytes_reg [4];
    cfg_t             cfg;

    // Front-to-back request queue
    logic             accept;
    tok_t             front_tok;
    tok_t             back_tok;
    logic             tok_empty;
    logic             tok_pop;

    // Back-to-result queue
    logic             res_full;
    logic             res_push;
    out_t             back_res;

    assign cfg.pattern_length = pattern_length_reg;
    assign cfg.pattern = {pattern_bytes_reg[3], pattern_bytes_reg[2],
                          pattern_bytes_reg[1], pattern_bytes_reg[0]};

    // Write the addressed register; drop writes to unused indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= '0;
            for (int i = 0; i < 4; i++)
                pattern_bytes_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PATTERN_LENGTH:  pattern_length_reg   <= cfg_data[LEN_W-1:0];
                REG_PATTERN_BYTES_0: pattern_bytes_reg[0] <= cfg_data;
                REG_PATTERN_BYTES_1: pattern_bytes_reg[1] <= cfg_data;
                REG_PATTERN_BYTES_2: pattern_bytes_reg[2] <= cfg_data;
                REG_PATTERN_BYTES_3: pattern_bytes_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // A byte is taken whenever the request queue has room
    assign accept = push && !full;

    // Front end: window shift, parallel compare, skip after a match
    lsoc_front #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .accept (accept),
        .item   (item),
        .tok    (front_tok)
    );

    // Hold classified requests so the back end may stall on its own
    lsoc_fifo #(
        .WIDTH ($bits(tok_t)),
        .DEPTH (TOK_DEPTH)
    ) u_tok_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (front_tok),
        .full  (full),
        .pop   (tok_pop),
        .dout  (back_tok),
        .empty (tok_empty)
    );

    // Back end: line and match counting, result building
    lsoc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (!tok_empty),
        .tok       (back_tok),
        .tok_pop   (tok_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (back_res)
    );

    // Result queue: the consumer may stall while new bytes keep coming
    lsoc_fifo #(
        .WIDTH ($bits(out_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (back_res),
        .full  (res_full),
        .pop   (pop),
        .dout  (result),
        .empty (empty)
    );

    // Per-line results are only emitted for lines that matched
    `LSOC_ASSERT_IMP(a_line_nonzero, clk, rst_n, !empty && !result.done_res,
        result.occurrences != 16'd0 && result.line_number != 32'd0,
        "per-line result without matches or line number")

    // found_none belongs to the closing result only
    `LSOC_ASSERT_IMP(a_none_on_done, clk, rst_n, !empty && result.found_none,
        result.done_res, "found_none set on a per-line result")

    // A closing request always leaves a result behind it
    `LSOC_ASSERT_NXT(a_close_emits, clk, rst_n, tok_pop && back_tok.closing,
        !empty, "closing request produced no result")

endmodule

[rtl/lsoc_fifo.sv]
// ---------------------------------------------------------------------------
// lsoc_fifo
// Small register queue with push/full and pop/empty sides.
// ---------------------------------------------------------------------------
module lsoc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W:0]   wr_ptr_reg;
    logic [PTR_W:0]   rd_ptr_reg;
    logic             do_push;
    logic             do_pop;

    assign full  = (wr_ptr_reg[PTR_W] != rd_ptr_reg[PTR_W]) &&
                   (wr_ptr_reg[PTR_W-1:0] == rd_ptr_reg[PTR_W-1:0]);
    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg[PTR_W-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg[PTR_W-1:0]] <= din;
    end

endmodule

[rtl/lsoc_front.sv]
// ---------------------------------------------------------------------------
// lsoc_front
// Byte window, parallel pattern compare and match-skip tracking.
// ---------------------------------------------------------------------------
module lsoc_front #(
    parameter int MAX_PATTERN = lsoc_pkg::MAX_PATTERN_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  lsoc_pkg::cfg_t cfg,
    input  logic           accept,
    input  lsoc_pkg::in_t  item,
    output lsoc_pkg::tok_t tok
);
    import lsoc_pkg::*;

    localparam int CNT_W  = $clog2(MAX_PATTERN + 1);
    localparam int SKIP_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [7:0]        win_reg  [MAX_PATTERN];
    logic [7:0]        win_next [MAX_PATTERN];
    logic [CNT_W-1:0]  bil_reg;
    logic [CNT_W-1:0]  bil_next;
    logic [SKIP_W-1:0] skip_reg;
    logic [SKIP_W-1:0] skip_next;
    logic [LEN_W-1:0]  eff_len;
    logic [MAX_PATTERN-1:0] lane_ok;
    logic              window_hit;
    logic              hit;
    logic              is_newline;

    assign eff_len = (cfg.pattern_length > LEN_W'(MAX_PATTERN)) ?
                     LEN_W'(MAX_PATTERN) : cfg.pattern_length;

    // Shift the new byte in at the newest end
    assign win_next[0] = item.text_byte;
    for (genvar j = 1; j < MAX_PATTERN; j++)
    begin : g_shift
        assign win_next[j] = win_reg[j-1];
    end

    assign bil_next = (bil_reg < CNT_W'(MAX_PATTERN)) ? bil_reg + 1'b1 : bil_reg;

    // Lane j compares window byte j with pattern byte (len - 1 - j)
    for (genvar j = 0; j < MAX_PATTERN; j++)
    begin : g_lane
        logic [LEN_W-1:0] pidx;
        assign pidx = eff_len - LEN_W'(1) - LEN_W'(j);
        assign lane_ok[j] = (LEN_W'(j) >= eff_len) ||
                            (win_next[j] == cfg.pattern[{pidx[4:0], 3'b000} +: 8]);
    end

    assign window_hit = (&lane_ok) && (eff_len != '0) && (LEN_W'(bil_next) >= eff_len);
    assign hit        = (skip_reg == '0) && window_hit;
    assign is_newline = (item.text_byte == NEWLINE);

    always_comb
    begin
        if (skip_reg != '0)
            skip_next = skip_reg - 1'b1;
        else if (window_hit)
            skip_next = SKIP_W'(eff_len - LEN_W'(1));
        else
            skip_next = '0;
    end

    assign tok.matched   = !item.end_of_text && hit;
    assign tok.newline   = !item.end_of_text && is_newline;
    assign tok.closing   = item.end_of_text;
    assign tok.has_bytes = (bil_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bil_reg  <= '0;
            skip_reg <= '0;
        end
        else if (accept)
        begin
            if (item.end_of_text || is_newline)
            begin
                bil_reg  <= '0;
                skip_reg <= '0;
            end
            else
            begin
                bil_reg  <= bil_next;
                skip_reg <= skip_next;
            end
        end
    end

    // Stale window bytes are masked by the line byte count
    always_ff @(posedge clk)
    begin
        if (accept && !item.end_of_text)
            win_reg <= win_next;
    end

endmodule

[rtl/lsoc_back.sv]
// ---------------------------------------------------------------------------
// lsoc_back
// Line and match counters; builds per-line and closing results.
// ---------------------------------------------------------------------------
module lsoc_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           tok_valid,
    input  lsoc_pkg::tok_t tok,
    output logic           tok_pop,
    input  logic           res_full,
    output logic           res_push,
    output lsoc_pkg::out_t res
);
    import lsoc_pkg::*;

    logic [15:0] lm_reg;
    logic [15:0] lm_inc;
    logic [31:0] line_reg;
    logic [31:0] line_inc;
    logic        any_reg;

    assign tok_pop  = tok_valid && !res_full;
    assign lm_inc   = (tok.matched && lm_reg != 16'hFFFF) ? lm_reg + 16'd1 : lm_reg;
    assign line_inc = (line_reg == 32'hFFFF_FFFF) ? line_reg : line_reg + 32'd1;

    always_comb
    begin
        res      = '0;
        res_push = 1'b0;
        if (tok.closing)
        begin
            res.line_number = tok.has_bytes ? line_inc : line_reg;
            res.occurrences = tok.has_bytes ? lm_reg : 16'd0;
            res.done_res    = 1'b1;
            res.found_none  = !any_reg;
            res_push        = tok_pop;
        end
        else
        begin
            res.line_number = line_inc;
            res.occurrences = lm_inc;
            res_push        = tok_pop && tok.newline && (lm_inc != 16'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lm_reg   <= '0;
            line_reg <= '0;
            any_reg  <= 1'b0;
        end
        else if (tok_pop)
        begin
            if (tok.closing)
            begin
                lm_reg   <= '0;
                line_reg <= '0;
                any_reg  <= 1'b0;
            end
            else if (tok.newline)
            begin
                lm_reg   <= '0;
                line_reg <= line_inc;
                any_reg  <= any_reg | tok.matched;
            end
            else
            begin
                lm_reg  <= lm_inc;
                any_reg <= any_reg | tok.matched;
            end
        end
    end

endmodule

[tb/occurrence_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Occurrence checker
// Watches the text, result and register channels of the substring counter,
// predicts every result from its own copy of the pattern and line state, and
// compares each popped result field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module occurrence_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  logic                              full,
    input  lsoc_pkg::in_t                     item,
    input  logic                              empty,
    input  logic                              pop,
    input  lsoc_pkg::out_t                    result,
    input  logic                              cfg_we,
    input  logic [lsoc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lsoc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                                mismatches,
    output int                                outstanding,
    output int                                checked
);
    import lsoc_pkg::*;

    localparam int WINDOW = MAX_PATTERN_DEF;

    // Register copy
    logic [5:0]  pat_len;
    logic [63:0] pat_word [4];

    // Text state
    logic [7:0]  window_q [WINDOW];
    logic [5:0]  line_fill;
    logic [4:0]  skip_left;
    logic [15:0] line_hits;
    logic [31:0] line_count;
    logic        seen_match;

    out_t expected_results[$];

    function automatic logic [7:0] pattern_at(int i);
        return pat_word[i / 8][(i % 8) * 8 +: 8];
    endfunction

    // Oldest window byte lines up with pattern byte 0.
    function automatic logic window_hit(int n);
        for (int i = 0; i < n; i++)
        begin
            if (window_q[n - 1 - i] != pattern_at(i))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [31:0] bump_line(logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    task automatic clear_line_state();
        for (int i = 0; i < WINDOW; i++)
        begin
            window_q[i] = '0;
        end
        line_fill = '0;
        skip_left = '0;
        line_hits = '0;
    endtask

    task automatic predict_request(in_t req);
        out_t want;
        int   n;
        want = '0;
        if (req.end_of_text)
        begin
            want.line_number = line_count;
            if (line_fill != 0)
            begin
                want.line_number = bump_line(line_count);
                want.occurrences = line_hits;
            end
            want.done_res   = 1'b1;
            want.found_none = !seen_match;
            expected_results.push_back(want);
            clear_line_state();
            line_count = '0;
            seen_match = 1'b0;
        end
        else
        begin
            for (int i = WINDOW - 1; i > 0; i--)
            begin
                window_q[i] = window_q[i - 1];
            end
            window_q[0] = req.text_byte;
            if (line_fill < WINDOW)
                line_fill++;
            n = (pat_len > WINDOW) ? WINDOW : int'(pat_len);
            if (skip_left != 0)
                skip_left--;
            else if (n > 0 && line_fill >= n && window_hit(n))
            begin
                if (line_hits != 16'hFFFF)
                    line_hits++;
                seen_match = 1'b1;
                skip_left  = 5'(n - 1);
            end
            if (req.text_byte == NEWLINE)
            begin
                line_count = bump_line(line_count);
                if (line_hits != 0)
                begin
                    want.line_number = line_count;
                    want.occurrences = line_hits;
                    expected_results.push_back(want);
                end
                clear_line_state();
            end
        end
    endtask

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    task automatic check_result(out_t got);
        out_t want;
        checked++;
        if (expected_results.size() == 0)
        begin
            $display("%0t: result with none expected, actual line %0d count %0d done %0b none %0b",
                     $time, got.line_number, got.occurrences, got.done_res, got.found_none);
            mismatches++;
        end
        else
        begin
            want = expected_results.pop_front();
            compare_field("line_number", want.line_number, got.line_number);
            compare_field("occurrences", 32'(want.occurrences), 32'(got.occurrences));
            compare_field("done_res", 32'(want.done_res), 32'(got.done_res));
            compare_field("found_none", 32'(want.found_none), 32'(got.found_none));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_len = '0;
            for (int k = 0; k < 4; k++)
            begin
                pat_word[k] = '0;
            end
            clear_line_state();
            line_count  = '0;
            seen_match  = 1'b0;
            expected_results.delete();
            mismatches  = 0;
            outstanding = 0;
            checked     = 0;
        end
        else
        begin
            if (pop && !empty)
                check_result(result);
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PATTERN_LENGTH:  pat_len     = cfg_data[LEN_W-1:0];
                    REG_PATTERN_BYTES_0: pat_word[0] = cfg_data;
                    REG_PATTERN_BYTES_1: pat_word[1] = cfg_data;
                    REG_PATTERN_BYTES_2: pat_word[2] = cfg_data;
                    REG_PATTERN_BYTES_3: pat_word[3] = cfg_data;
                    default: ;
                endcase
            end
            if (push && !full)
                predict_request(item);
            outstanding = expected_results.size();
        end
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Substring counter testbench
// Feeds text bytes and closing requests into the per-line substring counter
// under many pattern settings, drains results with a stalling receiver, and
// leaves prediction and comparison to the occurrence checker beside it.
// ---------------------------------------------------------------------------
module testbench;
    import lsoc_pkg::*;

    localparam int ITEM_TARGET   = 1550;   // requests to send in the whole run
    localparam int STALL_LIMIT   = 1000;   // cycles with no handshake before giving up
    localparam int SETTLE_CYCLES = 4;      // covers the path through both queues, plus margin
    localparam logic [7:0] CHAR_A = 8'h61;

    typedef enum int {DRAIN_STEADY, DRAIN_RANDOM, DRAIN_SPARSE} drain_mode_e;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  push      = 1'b0;
    logic                  pop       = 1'b0;
    in_t                   item      = '0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_PATTERN_LENGTH;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  full;
    logic                  empty;
    out_t                  result;

    int mismatches;
    int outstanding;
    int checked;

    // Stimulus bookkeeping: what the text generator knows of the pattern.
    int          items_sent    = 0;
    int          settings_used = 0;
    int          burst_left    = 0;
    int          idle_cycles   = 0;
    int          pat_len_now   = 0;
    logic [63:0] pat_words [4];
    logic [7:0]  alphabet [4];

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    line_substring_occurrence_counter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    occurrence_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .item        (item),
        .empty       (empty),
        .pop         (pop),
        .result      (result),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .checked     (checked)
    );

    // Watchdog: any cycle that moves a request or a result resets the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles at %0t", STALL_LIMIT, $time);
                $display("tb: failure");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: pick a drain mode for a stretch of cycles, then switch.
    // Steady draining gives stretches with no stall at all; sparse draining
    // backs the result queue up into the text side.
    initial
    begin : result_drain
        drain_mode_e mode;
        int          span;
        int          period;
        forever
        begin
            mode   = drain_mode_e'($urandom_range(0, 2));
            span   = $urandom_range(20, 300);
            period = $urandom_range(2, 8);
            for (int c = 0; c < span; c++)
            begin
                @(negedge clk);
                case (mode)
                    DRAIN_STEADY: pop <= 1'b1;
                    DRAIN_RANDOM: pop <= ($urandom_range(0, 3) != 0);
                    default:      pop <= ((c % period) == 0);
                endcase
            end
        end
    end

    // Send one request. Requests go out in bursts; between bursts hold push
    // low for a random gap. Drive at the falling edge, then advance rising
    // edges until one sees full low.
    task automatic send_request(logic [7:0] text, logic closing);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        item.text_byte   <= text;
        item.end_of_text <= closing;
        push             <= 1'b1;
        do @(posedge clk); while (full);
        items_sent++;
    endtask

    // Drop push and wait until every predicted result has been popped, then
    // let the pipeline drain requests that cause no result.
    task automatic settle();
        @(negedge clk);
        push <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Write all five registers; only call while the block is idle.
    task automatic set_pattern(int len, logic [63:0] w0, w1, w2, w3);
        pat_len_now  = len;
        pat_words[0] = w0;
        pat_words[1] = w1;
        pat_words[2] = w2;
        pat_words[3] = w3;
        settings_used++;
        write_reg(REG_PATTERN_LENGTH, 64'(len));
        write_reg(REG_PATTERN_BYTES_0, w0);
        write_reg(REG_PATTERN_BYTES_1, w1);
        write_reg(REG_PATTERN_BYTES_2, w2);
        write_reg(REG_PATTERN_BYTES_3, w3);
    endtask

    // Build a pattern from a small per-phase alphabet so that text made of
    // the same alphabet matches often and periodic patterns overlap. Bytes
    // past the length get random filler that must be ignored.
    task automatic pick_pattern(int phase);
        logic [63:0] w [4];
        int          len;
        int          mix;
        for (int k = 0; k < 4; k++)
        begin
            alphabet[k] = 8'($urandom_range(0, 255));
            w[k]        = {$urandom, $urandom};
        end
        if ($urandom_range(0, 3) == 0)
            alphabet[3] = NEWLINE;
        if ($urandom_range(0, 3) == 0)
            alphabet[2] = 8'h00;
        mix = $urandom_range(0, 9);
        if (phase == 0)
            len = 63;   // above the window size, acts as a full window
        else if (phase == 1)
            len = 32;
        else if (mix == 0)
            len = 0;
        else if (mix == 1)
            len = 1;
        else if (mix <= 5)
            len = $urandom_range(2, 4);
        else if (mix <= 8)
            len = $urandom_range(5, 32);
        else
            len = $urandom_range(33, 63);
        for (int i = 0; i < 32 && i < len; i++)
        begin
            w[i / 8][(i % 8) * 8 +: 8] = alphabet[$urandom_range(0, (mix < 7) ? 1 : 3)];
        end
        set_pattern(len, w[0], w[1], w[2], w[3]);
    endtask

    // Random text: mostly alphabet bytes and whole pattern copies, with
    // newlines, cut-off pattern copies, arbitrary bytes and the odd close.
    task automatic send_random_text(int span);
        int count;
        int pick;
        int eff;
        int cut;
        eff   = (pat_len_now > 32) ? 32 : pat_len_now;
        count = 0;
        while (count < span)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
                send_request(8'($urandom_range(0, 255)), 1'b1);
            else if (pick < 10)
                send_request(NEWLINE, 1'b0);
            else if (pick < 32 && eff > 0)
            begin
                cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, eff) : eff;
                for (int i = 0; i < cut; i++)
                begin
                    send_request(pat_words[i / 8][(i % 8) * 8 +: 8], 1'b0);
                end
                count += cut - 1;
            end
            else if (pick < 85)
                send_request(alphabet[$urandom_range(0, 3)], 1'b0);
            else
                send_request(8'($urandom_range(0, 255)), 1'b0);
            count++;
        end
    endtask

    initial
    begin : stimulus
        int phase;
        int span;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Empty pattern: nothing counts. Close after a finished line, then
        // close an empty text.
        set_pattern(0, '0, '0, '0, '0);
        send_request(CHAR_A, 1'b0);
        send_request(NEWLINE, 1'b0);
        send_request(8'hFF, 1'b1);
        send_request(8'h00, 1'b1);
        settle();

        // Zero byte then newline as the pattern; filler past the length is
        // all ones. The newline can only match where it closes a line.
        set_pattern(2, 64'hFFFF_FFFF_FFFF_0A00, '1, '1, '1);
        send_request(8'h00, 1'b0);
        send_request(NEWLINE, 1'b0);
        send_request(8'hFF, 1'b0);
        send_request(8'h00, 1'b0);
        send_request(8'h00, 1'b0);
        send_request(NEWLINE, 1'b0);
        send_request(NEWLINE, 1'b0);
        send_request(8'h00, 1'b1);
        settle();

        // Periodic pattern: matches must not overlap. Close a line that has
        // bytes and no newline.
        set_pattern(2, {48'h0, CHAR_A, CHAR_A}, '0, '0, '0);
        repeat (5) send_request(CHAR_A, 1'b0);
        send_request(NEWLINE, 1'b0);
        repeat (3) send_request(CHAR_A, 1'b0);
        send_request(8'hFF, 1'b1);
        settle();

        // Random phases until the request budget is spent. Half of them leave
        // the text open, so the next pattern takes effect in the middle of a
        // line.
        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            pick_pattern(phase);
            span = $urandom_range(60, 240);
            if (span > ITEM_TARGET - items_sent)
                span = ITEM_TARGET - items_sent;
            send_random_text(span);
            if ($urandom_range(0, 1) == 0)
                send_request(8'($urandom_range(0, 255)), 1'b1);
            settle();
            phase++;
        end

        $display("summary: %0d requests under %0d pattern settings, %0d results checked",
                 items_sent, settings_used, checked);
        $display("summary: empty, long, periodic and newline patterns, zero bytes, mid-line changes");
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
